[hw/rtl/sk_pkg.sv]
// shared types and constants of the spectral kurtosis estimator
`timescale 1ns / 1ps
`default_nettype none

package sk_pkg;

    localparam int MAX_INPUTS_DEF   = 2;
    localparam int MAX_CHANNELS_DEF = 1024;
    localparam int MAX_INTEG_DEF    = 4096;

    localparam int S1_W  = 20;
    localparam int S2_W  = 27;
    localparam int ENT_W = S1_W + S2_W;

    // divider dividend and divisor widths
    localparam int X_W = 73;
    localparam int D_W = 52;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INT_LEN  = 4'd0,
        CFG_COMB     = 4'd1,
        CFG_INPUTS   = 4'd2,
        CFG_CHANNELS = 4'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_RD,
        S_MUL,
        S_NEXT,
        S_SETUP,
        S_WLO,
        S_WHI,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic           start;
        logic [X_W-1:0] x;
        logic [D_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

[hw/rtl/spectral_kurtosis_rfi_estimator_unit.sv]
// spectral kurtosis estimator top level: control, sum update and kurtosis math
//
//   port group   dir  handshake               word
//   sample in    in   i_valid / o_stall       i_input_index, i_channel, i_sample
//   result out   out  o_valid / i_stall       o_out_input, o_out_channel, o_kurtosis,
//                                             o_zero_power, o_last
//   config       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a sample of an ordinary block is accepted in S_IDLE and its sums are read, modified
// and written in S_RMW; a sample outside the inputs or channels in use is dropped.
// a sample of a period's final block also walks the inputs, with one division per input
// of nonzero power and, in combined mode, one more for the result when none is zero,
// on the one-bit-per-cycle divider; results also wait while i_stall is high.
// after reset the sum memory is cleared, all MAX_INPUTS*MAX_CHANNELS entries, with o_stall high.
`timescale 1ns / 1ps
`default_nettype none

module spectral_kurtosis_rfi_estimator_unit import sk_pkg::*; #(
    parameter int MAX_INPUTS      = MAX_INPUTS_DEF,
    parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
    parameter int MAX_INTEGRATION = MAX_INTEG_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [3:0]            i_input_index,
    input  wire logic [9:0]            i_channel,
    input  wire logic [7:0]            i_sample,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [3:0]                 o_out_input,
    output logic [9:0]                 o_out_channel,
    output logic signed [23:0]         o_kurtosis,
    output logic                       o_zero_power,
    output logic                       o_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_INPUTS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    function automatic logic [7:0] f_power(input logic [7:0] s);
        logic [3:0] mr;
        logic [3:0] mi;
        mr = (s[7:4] >= 4'd8) ? s[7:4] - 4'd8 : 4'd8 - s[7:4];
        mi = (s[3:0] >= 4'd8) ? s[3:0] - 4'd8 : 4'd8 - s[3:0];
        return 8'(mr) * 8'(mr) + 8'(mi) * 8'(mi);
    endfunction

    // configuration
    logic [12:0] r_int_len;
    logic        r_comb;
    logic [4:0]  r_inputs;
    logic [10:0] r_channels;

    // control
    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_clr;
    logic [16:0]         r_bcnt;
    logic [MAX_INPUTS-1:0] r_started;

    // current item
    logic [IW-1:0] r_inp;
    logic [9:0]    r_ch;
    logic [7:0]    r_p;
    logic [AW-1:0] r_idx;
    logic          r_stb;
    logic          r_final;
    logic          r_bend;
    logic [24:0]   r_l2;
    logic [IW-1:0] r_i;

    // math
    logic [50:0] r_a;
    logic [39:0] r_b;
    logic        r_zacc;
    logic [54:0] r_sum;
    logic        r_neg;
    logic [54:0] r_mag;
    logic [16:0] r_fa;
    logic [16:0] r_fb;
    logic [39:0] r_db;
    logic [71:0] r_num;
    logic [51:0] r_den;
    logic        r_term;
    logic [23:0] r_kur;
    logic        r_zflag;

    // output register
    logic        r_ovalid;
    logic [3:0]  r_oinp;
    logic [9:0]  r_och;
    logic [23:0] r_okur;
    logic        r_ozero;
    logic        r_olast;

    logic [12:0] w_len;
    logic [4:0]  w_n;
    logic [10:0] w_c;
    logic [16:0] w_nl;
    logic        w_acc;
    logic        w_in_range;
    logic        w_final;
    logic [25:0] w_l2;
    logic [AW-1:0] w_idx_in;
    logic [AW-1:0] w_idx_rd;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [ENT_W-1:0] w_rdata;

    logic [15:0] w_p2;
    logic [20:0] w_t1;
    logic [27:0] w_t2;
    logic [S1_W-1:0] w_n1;
    logic [S2_W-1:0] w_n2;

    logic            w_vld;
    logic [S1_W-1:0] w_s1;
    logic [S2_W-1:0] w_s2;
    logic [39:0]     w_pa_s;
    logic [51:0]     w_pa_c;
    logic [39:0]     w_pb;

    logic [32:0] w_base;
    logic [43:0] w_plo;
    logic [44:0] w_phi;
    logic [43:0] w_dlo;
    logic [29:0] w_dhi;

    t_div_req       w_req;
    logic           w_div_done;
    logic [X_W-1:0] w_q;
    logic [50:0]    w_tq;
    logic [26:0]    w_q26;
    logic [25:0]    w_qr;
    logic [25:0]    w_qc;
    logic [23:0]    w_kur;

    logic w_more;
    logic w_last_sep;
    logic w_out_load;

    assign w_len = (r_int_len < 13'd2) ? 13'd2 :
                   (r_int_len > 13'(MAX_INTEGRATION)) ? 13'(MAX_INTEGRATION) : r_int_len;
    assign w_n   = (r_inputs < 5'd1) ? 5'd1 :
                   (r_inputs > 5'(MAX_INPUTS)) ? 5'(MAX_INPUTS) : r_inputs;
    assign w_c   = (r_channels < 11'd1) ? 11'd1 :
                   (r_channels > 11'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : r_channels;
    assign w_nl  = 17'(w_n) * 17'(w_len);
    assign w_l2  = 26'(w_len) * 26'(w_len);

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && (r_state == S_IDLE);
    assign w_in_range  = ({1'b0, i_input_index} < w_n) && ({1'b0, i_channel} < w_c);
    assign w_final     = ({1'b0, r_bcnt} + 18'd1) >= {1'b0, w_nl};
    assign w_idx_in    = AW'(32'(i_input_index) * MAX_CHANNELS) + AW'(i_channel);
    assign w_idx_rd    = AW'(32'(r_i) * MAX_CHANNELS) + AW'(r_ch);

    // sum update
    assign w_p2 = 16'(r_p) * 16'(r_p);
    assign w_t1 = {1'b0, w_rdata[S1_W-1:0]} + 21'(r_p);
    assign w_t2 = {1'b0, w_rdata[ENT_W-1:S1_W]} + 28'(w_p2);
    assign w_n1 = !r_stb ? S1_W'(r_p) : (w_t1[S1_W] ? {S1_W{1'b1}} : w_t1[S1_W-1:0]);
    assign w_n2 = !r_stb ? S2_W'(w_p2) : (w_t2[S2_W] ? {S2_W{1'b1}} : w_t2[S2_W-1:0]);

    assign w_we    = (r_state == S_CLEAR) || (r_state == S_RMW);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : {w_n2, w_n1};
    assign w_raddr = (r_state == S_IDLE) ? w_idx_in : w_idx_rd;

    sk_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // per input read of the final block; inputs not yet started, but for the sample's own, count as empty
    assign w_vld  = r_started[r_i] || (r_i == r_inp);
    assign w_s1   = w_vld ? w_rdata[S1_W-1:0] : '0;
    assign w_s2   = w_vld ? w_rdata[ENT_W-1:S1_W] : '0;
    assign w_pa_s = 40'(w_len) * 40'(w_s2);
    assign w_pa_c = 52'(r_l2) * 52'(w_s2);
    assign w_pb   = 40'(w_s1) * 40'(w_s1);

    assign w_base = {w_nl, 16'b0};
    assign w_plo  = 44'(r_fa) * 44'(r_mag[26:0]);
    assign w_phi  = 45'(r_fa) * 45'(r_mag[54:27]);
    assign w_dlo  = 44'(r_fb) * 44'(r_db[26:0]);
    assign w_dhi  = 30'(r_fb) * 30'(r_db[39:27]);

    always_comb begin
        w_req.start = (r_state == S_DIV_GO);
        if (r_term) begin
            w_req.x   = {6'b0, r_a, 16'b0};
            w_req.den = {12'b0, r_b};
        end else if (r_comb) begin
            w_req.x   = {r_num, 1'b0};
            w_req.den = r_den;
        end else begin
            w_req.x   = {r_num[55:0], 17'b0};
            w_req.den = r_den;
        end
    end

    sk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    // quotient saturation and round half away from zero
    assign w_tq  = (w_q > {22'b0, 51'd1 << 50}) ? (51'd1 << 50) : w_q[50:0];
    assign w_q26 = (w_q > {46'b0, 27'd1 << 26}) ? (27'd1 << 26) : w_q[26:0];
    assign w_qr  = 26'((w_q26 + 27'd1) >> 1);
    always_comb begin
        if (r_neg) begin
            w_qc = (w_qr > (26'd1 << 23)) ? (26'd1 << 23) : w_qr;
        end else begin
            w_qc = (w_qr > ((26'd1 << 23) - 26'd1)) ? ((26'd1 << 23) - 26'd1) : w_qr;
        end
    end
    assign w_kur = r_neg ? 24'(26'd0 - w_qc) : 24'(w_qc);

    assign w_more     = (5'(r_i) + 5'd1) < w_n;
    assign w_last_sep = (5'(r_i) + 5'd1) == w_n;
    assign w_out_load = (r_state == S_EMIT) && (!r_ovalid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_acc && w_in_range) n_state = S_RMW;
            end
            S_RMW: begin
                n_state = r_final ? S_RD : S_IDLE;
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (w_s1 == '0) begin
                    n_state = r_comb ? S_NEXT : S_EMIT;
                end else begin
                    n_state = r_comb ? S_DIV_GO : S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_WLO;
            end
            S_WLO: begin
                n_state = S_WHI;
            end
            S_WHI: begin
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) n_state = r_term ? S_NEXT : S_EMIT;
            end
            S_NEXT: begin
                if (w_more) begin
                    n_state = S_RD;
                end else if (r_comb) begin
                    n_state = r_zacc ? S_EMIT : S_SETUP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EMIT: begin
                if (w_out_load) n_state = r_comb ? S_FIN : S_NEXT;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_bcnt     <= '0;
            r_started  <= '0;
            r_int_len  <= 13'd256;
            r_comb     <= 1'b0;
            r_inputs   <= 5'd2;
            r_channels <= 11'd1024;
        end else begin
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_INT_LEN:  r_int_len  <= i_cfg_data;
                    CFG_COMB:     r_comb     <= i_cfg_data[0];
                    CFG_INPUTS:   r_inputs   <= i_cfg_data[4:0];
                    CFG_CHANNELS: r_channels <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (r_state == S_RMW && !r_final && r_bend) begin
                r_bcnt           <= r_bcnt + 17'd1;
                r_started[r_inp] <= 1'b1;
            end
            if (r_state == S_FIN && r_bend) begin
                r_bcnt    <= '0;
                r_started <= '0;
            end
        end
    end

    // item and math registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_inp   <= IW'(i_input_index);
                r_ch    <= i_channel;
                r_p     <= f_power(i_sample);
                r_idx   <= w_idx_in;
                r_stb   <= r_started[IW'(i_input_index)];
                r_final <= w_final;
                r_bend  <= ({1'b0, i_channel} == w_c - 11'd1);
                r_l2    <= 25'(w_l2);
            end
            S_RMW: begin
                r_i    <= '0;
                r_sum  <= '0;
                r_zacc <= 1'b0;
            end
            S_MUL: begin
                r_a     <= r_comb ? 51'(w_pa_c) : 51'(w_pa_s);
                r_b     <= w_pb;
                r_term  <= r_comb;
                r_kur   <= '0;
                r_zflag <= 1'b1;
                if (w_s1 == '0) r_zacc <= 1'b1;
            end
            S_SETUP: begin
                r_term <= 1'b0;
                if (r_comb) begin
                    r_neg <= r_sum < 55'(w_base);
                    r_mag <= (r_sum < 55'(w_base)) ? 55'(w_base) - r_sum
                                                   : r_sum - 55'(w_base);
                    r_fa  <= w_nl + 17'd1;
                    r_fb  <= w_nl;
                    r_db  <= 40'(w_nl - 17'd1);
                end else begin
                    r_neg <= r_a[39:0] < r_b;
                    r_mag <= (r_a[39:0] < r_b) ? 55'(r_b - r_a[39:0])
                                               : 55'(r_a[39:0] - r_b);
                    r_fa  <= 17'(w_len) + 17'd1;
                    r_fb  <= 17'(w_len) - 17'd1;
                    r_db  <= r_b;
                end
            end
            S_WLO: begin
                r_num <= 72'(w_plo);
                r_den <= 52'(w_dlo);
            end
            S_WHI: begin
                r_num <= r_num + {w_phi, 27'b0};
                r_den <= r_den + 52'({w_dhi, 27'b0});
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    if (r_term) begin
                        r_sum <= r_sum + 55'(w_tq);
                    end else begin
                        r_kur   <= w_kur;
                        r_zflag <= 1'b0;
                    end
                end
            end
            S_NEXT: begin
                if (w_more) r_i <= r_i + IW'(1);
                // combined result with an empty sum
                r_kur   <= '0;
                r_zflag <= 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_oinp  <= r_comb ? 4'd0 : 4'(r_i);
            r_och   <= r_ch;
            r_okur  <= r_kur;
            r_ozero <= r_zflag;
            r_olast <= r_comb ? 1'b1 : w_last_sep;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_input   = r_oinp;
    assign o_out_channel = r_och;
    assign o_kurtosis    = r_okur;
    assign o_zero_power  = r_ozero;
    assign o_last        = r_olast;

endmodule

`default_nettype wire

[hw/rtl/sk_mem.sv]
// sum memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module sk_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 47,
    parameter int AW    = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sk_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sk_div import sk_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_div_req       i_req,
    output logic                o_done,
    output logic [X_W-1:0]      o_q
);

    localparam int CW = $clog2(X_W + 1);

    logic [X_W-1:0] r_x;
    logic [X_W-1:0] r_q;
    logic [D_W-1:0] r_den;
    logic [D_W-1:0] r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [D_W:0]   w_t;
    logic [D_W:0]   w_diff;
    logic           w_ge;

    assign w_t    = {r_rem, r_x[X_W-1]};
    assign w_ge   = w_t >= {1'b0, r_den};
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_den <= i_req.den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= CW'(X_W);
        end else if (r_busy) begin
            r_x   <= {r_x[X_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_t[D_W-1:0];
            r_q   <= {r_q[X_W-2:0], w_ge};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

[test/sk_result_checker.sv]
// result checker for the spectral kurtosis estimator: watches the channels, predicts and compares
`timescale 1ns / 1ps

module sk_result_checker import sk_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  o_stall,
    input  wire logic [3:0]            i_input_index,
    input  wire logic [9:0]            i_channel,
    input  wire logic [7:0]            i_sample,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire logic [3:0]            o_out_input,
    input  wire logic [9:0]            o_out_channel,
    input  wire logic signed [23:0]    o_kurtosis,
    input  wire logic                  o_zero_power,
    input  wire logic                  o_last,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         mismatches,
    output int                         awaiting
);

    localparam int NIN = MAX_INPUTS_DEF;
    localparam int NCH = MAX_CHANNELS_DEF;
    localparam longint unsigned S1_MAX = 64'hFFFFF;
    localparam longint unsigned S2_MAX = 64'h7FFFFFF;

    typedef struct packed {
        logic [3:0]  inp;
        logic [9:0]  ch;
        logic [23:0] kur;
        logic        zp;
        logic        last;
    } t_estimate;

    t_estimate kurt_q[$];

    bit [S1_W-1:0] pwr_sum [0:NIN*NCH-1];
    bit [S2_W-1:0] pwr_sq_sum [0:NIN*NCH-1];
    bit [16:0]     blk_cnt;
    bit [15:0]     started_mask;

    bit [12:0] reg_len;
    bit        reg_comb;
    bit [4:0]  reg_inputs;
    bit [10:0] reg_chans;

    function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                                 int fb, longint unsigned cap);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q > cap) return cap;
        for (int k = 0; k < fb; k++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > cap) return cap;
        end
        return q;
    endfunction

    // round half away from zero, then saturate to 24-bit signed
    function automatic logic [23:0] round_q16(bit neg, longint unsigned num,
                                              longint unsigned den, int fb);
        longint unsigned q;
        longint unsigned cap;
        q = frac_div(num, den, fb + 1, 64'd1 << 26);
        cap = neg ? (64'd1 << 23) : ((64'd1 << 23) - 1);
        q = (q + 1) >> 1;
        if (q > cap) q = cap;
        return neg ? 24'(-q) : 24'(q);
    endfunction

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_estimates(int unsigned inp, int unsigned ch, bit [7:0] smp);
        int unsigned ln, nin, nch, pw, idx;
        int re, im;
        longint unsigned m, s1, s2, acc, base, mag, a, b, x, y;
        bit fin, zero, neg, live;
        t_estimate e;
        ln  = clamp(reg_len, 2, MAX_INTEG_DEF);
        nin = clamp(reg_inputs, 1, NIN);
        nch = clamp(reg_chans, 1, NCH);
        if (inp >= nin || ch >= nch) return;
        re = int'(smp[7:4]) - 8;
        im = int'(smp[3:0]) - 8;
        pw = re * re + im * im;
        idx = inp * NCH + ch;
        if (!started_mask[inp]) begin
            pwr_sum[idx] = pw;
            pwr_sq_sum[idx] = pw * pw;
        end else begin
            x = longint'(pwr_sum[idx]) + pw;
            y = longint'(pwr_sq_sum[idx]) + pw * pw;
            pwr_sum[idx] = x > S1_MAX ? S1_MAX : x;
            pwr_sq_sum[idx] = y > S2_MAX ? S2_MAX : y;
        end
        fin = (blk_cnt + 1) >= nin * ln;
        if (fin) begin
            if (reg_comb) begin
                m = nin * ln;
                acc = 0;
                zero = 0;
                for (int i = 0; i < nin; i++) begin
                    live = started_mask[i] || i == inp;
                    s1 = live ? pwr_sum[i*NCH+ch] : 0;
                    s2 = live ? pwr_sq_sum[i*NCH+ch] : 0;
                    if (s1 == 0) zero = 1;
                    else acc += frac_div(longint'(ln) * ln * s2, s1 * s1, 16, 64'd1 << 50);
                end
                e = '{inp: 4'd0, ch: 10'(ch), kur: 24'd0, zp: zero, last: 1'b1};
                if (!zero) begin
                    base = m << 16;
                    neg = acc < base;
                    mag = neg ? base - acc : acc - base;
                    e.kur = round_q16(neg, (m + 1) * mag, m * (m - 1), 0);
                end
                kurt_q.push_back(e);
            end else begin
                m = ln;
                for (int i = 0; i < nin; i++) begin
                    live = started_mask[i] || i == inp;
                    s1 = live ? pwr_sum[i*NCH+ch] : 0;
                    s2 = live ? pwr_sq_sum[i*NCH+ch] : 0;
                    e = '{inp: 4'(i), ch: 10'(ch), kur: 24'd0, zp: s1 == 0,
                          last: i + 1 == nin};
                    if (s1 != 0) begin
                        a = m * s2;
                        b = s1 * s1;
                        neg = a < b;
                        mag = neg ? b - a : a - b;
                        e.kur = round_q16(neg, (m + 1) * mag, (m - 1) * b, 16);
                    end
                    kurt_q.push_back(e);
                end
            end
        end
        if (ch == nch - 1) begin
            if (fin) begin
                blk_cnt = 0;
                started_mask = 0;
            end else begin
                blk_cnt = blk_cnt + 1;
                started_mask[inp] = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        awaiting = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pwr_sum[k]) begin
                pwr_sum[k] = 0;
                pwr_sq_sum[k] = 0;
            end
            blk_cnt = 0;
            started_mask = 0;
            reg_len = 13'd256;
            reg_comb = 1'b0;
            reg_inputs = 5'd2;
            reg_chans = 11'd1024;
            kurt_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_INT_LEN:  reg_len = i_cfg_data[12:0];
                    CFG_COMB:     reg_comb = i_cfg_data[0];
                    CFG_INPUTS:   reg_inputs = i_cfg_data[4:0];
                    CFG_CHANNELS: reg_chans = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                predict_estimates(i_input_index, i_channel, i_sample);
            if (o_valid && !i_stall) begin
                if (kurt_q.size() == 0) begin
                    report_mismatch("unexpected word, channel", o_out_channel, -1);
                end else begin
                    t_estimate e;
                    e = kurt_q.pop_front();
                    if (o_out_input !== e.inp)
                        report_mismatch("out_input", o_out_input, e.inp);
                    if (o_out_channel !== e.ch)
                        report_mismatch("out_channel", o_out_channel, e.ch);
                    if (o_kurtosis !== e.kur)
                        report_mismatch("kurtosis", o_kurtosis, $signed(e.kur));
                    if (o_zero_power !== e.zp)
                        report_mismatch("zero_power", o_zero_power, e.zp);
                    if (o_last !== e.last)
                        report_mismatch("last", o_last, e.last);
                end
            end
        end
        awaiting = kurt_q.size();
    end

endmodule

[test/tb_spectral_kurtosis_rfi_estimator_unit.sv]
// testbench top for the spectral kurtosis estimator: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_spectral_kurtosis_rfi_estimator_unit;
    import sk_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [3:0]            i_input_index = '0;
    logic [9:0]            i_channel = '0;
    logic [7:0]            i_sample = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [3:0]            o_out_input;
    logic [9:0]            o_out_channel;
    logic signed [23:0]    o_kurtosis;
    logic                  o_zero_power;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int mismatches;
    int awaiting;
    int send_idle_pct = 38;
    int recv_stall_pct = 54;
    int accepted_words;
    int nin, nch;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    spectral_kurtosis_rfi_estimator_unit DUT (.*);

    sk_result_checker u_checker (.*);

    task automatic send_word(int inp, int ch, int smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_input_index <= 4'(inp);
        i_channel <= 10'(ch);
        i_sample <= 8'(smp);
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
        // ignored or accumulating words may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int len, int comb, int inputs, int chans);
        drain();
        cfg_write(CFG_INT_LEN, len);
        cfg_write(CFG_COMB, comb);
        cfg_write(CFG_INPUTS, inputs);
        cfg_write(CFG_CHANNELS, chans);
        nin = inputs < 1 ? 1 : (inputs > MAX_INPUTS_DEF ? MAX_INPUTS_DEF : inputs);
        nch = chans < 1 ? 1 : (chans > MAX_CHANNELS_DEF ? MAX_CHANNELS_DEF : chans);
    endtask

    // one block of one input, sometimes broken off, with some noise mixed in
    task automatic send_block();
        int inp;
        inp = $urandom_range(nin - 1);
        for (int ch = 0; ch < nch; ch++) begin
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(1))
                    send_word($urandom_range(15, nin), $urandom_range(1023), $urandom);
                else
                    send_word($urandom_range(15), $urandom_range(1023, nch), $urandom);
            end
            if ($urandom_range(99) < 4) ch = $urandom_range(nch - 1);
            send_word(inp, ch, $urandom_range(255));
            accepted_words++;
            if ($urandom_range(199) == 0) drain();
        end
    endtask

    initial begin
        accepted_words = 0;
        nin = 2;
        nch = 1024;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a couple of words under the reset settings
        send_word(0, 0, 8'hFF);
        send_word(1, 5, 8'h00);

        // separate mode: extremes, zero power, ignored words, a full period
        set_config(2, 0, 2, 2);
        send_word(0, 0, 8'h00);
        send_word(0, 1, 8'hFF);
        send_word(1, 0, 8'h88);
        send_word(1, 1, 8'h0F);
        send_word(15, 0, 8'h12);
        send_word(0, 1023, 8'h34);
        send_word(0, 0, 8'hF0);
        send_word(0, 1, 8'h80);
        send_word(0, 0, 8'h08);
        send_word(0, 1, 8'h88);

        // combined mode, a final block with the other input started, then two blocks of the next period
        set_config(2, 1, 2, 2);
        send_word(1, 0, 8'h3C);
        send_word(1, 1, 8'hA5);
        send_word(0, 0, 8'h77);
        send_word(0, 1, 8'h99);
        send_word(1, 0, 8'h5A);
        send_word(1, 1, 8'hC3);
        send_word(0, 0, 8'hE1);
        send_word(0, 1, 8'h1E);
        send_word(1, 0, 8'h88);
        send_word(1, 1, 8'h6B);
        send_word(0, 0, 8'h42);
        send_word(0, 1, 8'h24);

        // random settings, including raw values outside the clamped ranges
        while (accepted_words < 320) begin
            if (accepted_words >= 214) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (accepted_words >= 107) begin
                send_idle_pct = 54;
                recv_stall_pct = 38;
            end
            set_config($urandom_range(99) < 10 ? $urandom_range(1) : $urandom_range(2, 4),
                       $urandom_range(1),
                       $urandom_range(99) < 10 ? 31 * $urandom_range(1) : $urandom_range(1, 2),
                       $urandom_range(99) < 10 ? 0 : $urandom_range(1, 6));
            repeat ($urandom_range(3, 8)) send_block();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #60ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
